[hw/rtl/spq_pkg.sv]
// spq_pkg: shared types and default constants for the sorted priority queue
// no dependencies; imported by every module of the block
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int PRIO_BITS_DEF    = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   // width of the capacity register
   localparam int CAP_BITS         = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } spq_op_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
   } spq_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// spq_cell: one storage slot of the sorted chain
// depends on spq_pkg for the command struct
`default_nettype none

module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS    = PRIO_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire spq_cmd_type             cmd,
   input  wire logic                    occupied,
   input  wire logic [PRIO_BITS-1:0]    new_prio,
   input  wire logic [PAYLOAD_BITS-1:0] new_payload,
   input  wire logic                    left_keep,
   input  wire logic [PRIO_BITS-1:0]    left_prio,
   input  wire logic [PAYLOAD_BITS-1:0] left_payload,
   input  wire logic [PRIO_BITS-1:0]    right_prio,
   input  wire logic [PAYLOAD_BITS-1:0] right_payload,
   output logic                         keep,
   output logic [PRIO_BITS-1:0]         prio,
   output logic [PAYLOAD_BITS-1:0]      payload
);

   logic [PRIO_BITS-1:0]    prio_ff,    prio_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // entry stays put on insert when it ranks at or above the new one
   assign keep = occupied && (prio_ff >= new_prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      priority if (cmd.pop) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end else if (cmd.push && !keep) begin
         if (left_keep) begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end else begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

[hw/rtl/spq_chain.sv]
// spq_chain: row of spq_cell slots, each linked to both neighbors
// depends on spq_pkg and spq_cell
`default_nettype none

module spq_chain
   import spq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int PRIO_BITS    = PRIO_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   parameter int CNT_W        = $clog2(DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire spq_cmd_type             cmd,
   input  wire logic [CNT_W-1:0]        count,
   input  wire logic [PRIO_BITS-1:0]    new_prio,
   input  wire logic [PAYLOAD_BITS-1:0] new_payload,
   output logic [PRIO_BITS-1:0]         head_prio,
   output logic [PAYLOAD_BITS-1:0]      head_payload
);

   logic [PRIO_BITS-1:0]    prio_q    [DEPTH];
   logic [PAYLOAD_BITS-1:0] payload_q [DEPTH];
   logic [DEPTH-1:0]        keep_q;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    l_keep;
      logic [PRIO_BITS-1:0]    l_prio, r_prio;
      logic [PAYLOAD_BITS-1:0] l_payload, r_payload;

      if (i == 0) begin : g_first
         // head slot takes the new entry unless it keeps its own
         assign l_keep    = 1'b1;
         assign l_prio    = '0;
         assign l_payload = '0;
      end else begin : g_mid
         assign l_keep    = keep_q[i-1];
         assign l_prio    = prio_q[i-1];
         assign l_payload = payload_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_prio    = '0;
         assign r_payload = '0;
      end else begin : g_inner
         assign r_prio    = prio_q[i+1];
         assign r_payload = payload_q[i+1];
      end

      spq_cell #(
         .PRIO_BITS    (PRIO_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .occupied      (CNT_W'(i) < count),
         .new_prio      (new_prio),
         .new_payload   (new_payload),
         .left_keep     (l_keep),
         .left_prio     (l_prio),
         .left_payload  (l_payload),
         .right_prio    (r_prio),
         .right_payload (r_payload),
         .keep          (keep_q[i]),
         .prio          (prio_q[i]),
         .payload       (payload_q[i])
      );
   end

   assign head_prio    = prio_q[0];
   assign head_payload = payload_q[0];

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// sorted_priority_queue: top level, count and capacity control around the cell chain
// depends on spq_pkg and spq_chain
//
//   channel   ports                      handshake
//   request   req_op/priority/element    start high and busy low at clock edge
//   response  rsp_*                      rsp_valid high for one cycle, no stall
//   config    csr_wdata                  csr_we high at clock edge
//
// one request per cycle: every cell compares, shifts or holds in the same edge
// the response shows in the cycle after its request and reflects the state after it
// busy is always low; the chain never has to stall a request
// reset (synchronous, active high) empties the queue and loads capacity DEPTH
// the receiver cannot stall responses, so none are buffered
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int PRIO_BITS    = PRIO_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int CNT_W       = $clog2(DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_op,
   input  wire logic [PRIO_BITS-1:0]    req_priority_req,
   input  wire logic [PAYLOAD_BITS-1:0] req_element,
   // response channel
   output logic                         rsp_valid,
   output logic                         rsp_removed_valid,
   output logic [PRIO_BITS-1:0]         rsp_removed_priority,
   output logic [PAYLOAD_BITS-1:0]      rsp_removed_element,
   output logic [PRIO_BITS-1:0]         rsp_head_priority,
   output logic [PAYLOAD_BITS-1:0]      rsp_head_element,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic                         rsp_is_full,
   output logic                         rsp_rejected,
   // capacity register
   input  wire logic                    csr_we,
   input  wire logic [CAP_BITS-1:0]     csr_wdata
);

   // compare width wide enough for both count and capacity
   localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic [CAP_BITS-1:0]     cap_ff,   cap_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff;
   logic                    removed_valid_ff, removed_valid_in;
   logic                    rejected_ff,      rejected_in;
   logic [PRIO_BITS-1:0]    removed_prio_ff,  removed_prio_in;
   logic [PAYLOAD_BITS-1:0] removed_elem_ff,  removed_elem_in;

   logic                    accept;
   logic [CMP_W-1:0]        cap_raw, cap_eff;
   logic                    full;
   spq_cmd_type             cmd;
   logic [PRIO_BITS-1:0]    head_prio;
   logic [PAYLOAD_BITS-1:0] head_payload;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // capacity saturated to 1..DEPTH; a zero acts as one
   assign cap_raw = CMP_W'(cap_ff);
   always_comb begin
      priority if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = cap_raw;
      end
   end

   assign full = CMP_W'(count_ff) >= cap_eff;

   // decode the request into a chain command, rejecting at the bounds
   always_comb begin
      cmd              = '0;
      count_in         = count_ff;
      removed_valid_in = 1'b0;
      rejected_in      = 1'b0;
      removed_prio_in  = '0;
      removed_elem_in  = '0;
      if (accept) begin
         unique case (spq_op_type'(req_op))
            OP_INSERT: begin
               if (full) begin
                  rejected_in = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (count_ff == '0) begin
                  rejected_in = 1'b1;
               end else begin
                  cmd.pop          = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
                  removed_valid_in = 1'b1;
                  removed_prio_in  = head_prio;
                  removed_elem_in  = head_payload;
               end
            end
            default: begin
               rejected_in = 1'b0;
            end
         endcase
      end
   end

   assign cap_in = csr_we ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_BITS'(DEPTH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      removed_valid_ff <= removed_valid_in;
      rejected_ff      <= rejected_in;
      removed_prio_ff  <= removed_prio_in;
      removed_elem_ff  <= removed_elem_in;
   end

   // sorted storage: head sits in cell zero
   spq_chain #(
      .DEPTH        (DEPTH),
      .PRIO_BITS    (PRIO_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_W        (CNT_W)
   ) u_chain (
      .clock        (clock),
      .cmd          (cmd),
      .count        (count_ff),
      .new_prio     (req_priority_req),
      .new_payload  (req_element),
      .head_prio    (head_prio),
      .head_payload (head_payload)
   );

   // head and count are read straight from state, already past the request
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_removed_valid    = removed_valid_ff;
   assign rsp_removed_priority = removed_prio_ff;
   assign rsp_removed_element  = removed_elem_ff;
   assign rsp_head_priority    = (count_ff == '0) ? '0 : head_prio;
   assign rsp_head_element     = (count_ff == '0) ? '0 : head_payload;
   assign rsp_entry_count      = count_ff;
   assign rsp_is_full          = full;
   assign rsp_rejected         = rejected_ff;

endmodule

`default_nettype wire

[hw/rtl/spq_checker.sv]
// spq_checker: port-level assertions for sorted_priority_queue, with its bind
// depends on spq_pkg; bound to sorted_priority_queue
`default_nettype none

module spq_checker
   import spq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int PRIO_BITS    = PRIO_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int CNT_W       = $clog2(DEPTH + 1)
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    req_op,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_removed_valid,
   input wire logic                    rsp_rejected,
   input wire logic [PRIO_BITS-1:0]    rsp_head_priority,
   input wire logic [PAYLOAD_BITS-1:0] rsp_head_element,
   input wire logic [CNT_W-1:0]        rsp_entry_count
);

   // each request gets exactly one response, in the cycle after it
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without request");

   // a removal only comes from a remove request and never with a reject
   a_removed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_removed_valid) |->
         (!rsp_rejected && $past(req_op) == OP_REMOVE))
      else $error("bad removal");

   // an empty queue shows a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_count == '0) |->
         (rsp_head_priority == '0 && rsp_head_element == '0))
      else $error("empty queue with nonzero head");

endmodule

bind sorted_priority_queue spq_checker #(
   .DEPTH        (DEPTH),
   .PRIO_BITS    (PRIO_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_removed_valid (rsp_removed_valid),
   .rsp_rejected      (rsp_rejected),
   .rsp_head_priority (rsp_head_priority),
   .rsp_head_element  (rsp_head_element),
   .rsp_entry_count   (rsp_entry_count)
);

`default_nettype wire
